/* rtl/qwt_pkg.sv */
// qwt_pkg: constants, types and helpers for the quoted word tokenizer
// used by rtl/quoted_word_tokenizer.sv; depends on nothing else

package qwt_pkg;

    localparam int LINE_BITS     = 24;
    localparam int REC_LINE_BITS = 24;
    localparam int BYTE_BITS     = 8;
    localparam int OUT_BITS      = 40;
    localparam int ADDR_BITS     = 3;

    localparam logic [BYTE_BITS-1:0] CH_NL    = 8'h0A;
    localparam logic [BYTE_BITS-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_BITS-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_BITS-1:0] CH_HASH  = 8'h23;
    localparam logic [BYTE_BITS-1:0] CH_BSL   = 8'h5C;
    localparam logic [BYTE_BITS-1:0] CH_DQ    = 8'h22;
    localparam logic [BYTE_BITS-1:0] CH_SQ    = 8'h27;
    localparam logic [BYTE_BITS-1:0] CH_UC_A  = 8'h41;
    localparam logic [BYTE_BITS-1:0] CH_UC_Z  = 8'h5A;
    localparam logic [BYTE_BITS-1:0] CASE_OFS = 8'h20;

    localparam logic       ACT_DATA = 1'b0;
    localparam logic       ACT_EOS  = 1'b1;

    localparam logic [ADDR_BITS-1:0] ADDR_LOWERCASE = 3'd0;

    typedef logic [LINE_BITS-1:0] t_line;

    typedef struct packed {
        logic [OUT_BITS-37:0]     pad;
        logic                     quote_error;
        logic [REC_LINE_BITS-1:0] record_line;
        logic                     record_done;
        logic                     word_done;
        logic [BYTE_BITS-1:0]     char_out;
        logic                     char_valid;
    } t_result;

    // line counter value narrowed or widened to the reported width
    function automatic logic [REC_LINE_BITS-1:0] to_rec_line(t_line v);
        logic [LINE_BITS+REC_LINE_BITS-1:0] w;
        w = {{REC_LINE_BITS{1'b0}}, v};
        return w[REC_LINE_BITS-1:0];
    endfunction

endpackage

/* rtl/quoted_word_tokenizer.sv */
// quoted_word_tokenizer: shell-style word and line-record splitter, one byte per cycle unless the output stalls
// depends on rtl/qwt_pkg.sv
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  tdata = byte_in, tuser = action
//  m_*       out  m_tvalid/m_tready  tdata = result fields, tlast = stream_done
//  apb       in   psel/penable       reg 0 at 0x0: lowercase_enable
//
// one word in, one word out; result appears the cycle after acceptance
// throughput one word per cycle while m_tready is high, set by the single result register
// s_tready is high while the result register is empty or being drained
// synchronous active-low reset resets flags and counters and marks the result register empty

module quoted_word_tokenizer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [qwt_pkg::BYTE_BITS-1:0] s_tdata,   // [7:0] byte_in
    input  logic                         s_tuser,   // [0] action
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [0] char_valid, [8:1] char_out, [9] word_done, [10] record_done,
    // [34:11] record_line, [35] quote_error, [39:36] zero
    output logic [qwt_pkg::OUT_BITS-1:0]  m_tdata,
    output logic                         m_tlast,   // stream_done
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [qwt_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    logic             r_lower;
    logic             r_dq, r_sq, r_comment, r_esc, r_word_open, r_rhw, r_await;
    qwt_pkg::t_line   r_nl, r_start;
    logic             n_dq, n_sq, n_comment, n_esc, n_word_open, n_rhw, n_await;
    qwt_pkg::t_line   n_nl, n_start;

    logic             r_m_valid;
    qwt_pkg::t_result r_res, n_res;
    logic             r_last, n_last;

    logic             accept;
    logic             quoted;
    logic             rhw_now;
    logic             comment_now;
    logic [qwt_pkg::BYTE_BITS-1:0] c;
    qwt_pkg::t_line   nl_inc;

    assign pready   = 1'b1;
    assign prdata   = (paddr == qwt_pkg::ADDR_LOWERCASE) ? {31'd0, r_lower} : 32'd0;
    assign s_tready = !r_m_valid || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_res;
    assign m_tlast  = r_last;

    assign c      = s_tdata;
    assign quoted = r_dq || r_sq;
    assign nl_inc = r_nl + qwt_pkg::t_line'(1);

    always_comb begin
        n_dq        = r_dq;
        n_sq        = r_sq;
        n_comment   = r_comment;
        n_esc       = r_esc;
        n_word_open = r_word_open;
        n_rhw       = r_rhw;
        n_await     = r_await;
        n_nl        = r_nl;
        n_start     = r_start;
        n_res       = '0;
        n_last      = 1'b0;
        rhw_now     = 1'b0;
        comment_now = 1'b0;
        if (s_tuser == qwt_pkg::ACT_EOS) begin
            n_last = 1'b1;
            if (r_esc) begin
                n_res.char_valid = 1'b1;
                n_res.char_out   = qwt_pkg::CH_BSL;
                if (r_await) begin
                    n_start = nl_inc;
                end
            end
            n_res.quote_error = quoted;
            n_res.word_done   = r_word_open || r_esc;
            rhw_now           = r_rhw || r_word_open || r_esc;
            if (rhw_now) begin
                n_res.record_done = 1'b1;
                n_res.record_line = qwt_pkg::to_rec_line(n_start);
            end
            n_dq        = 1'b0;
            n_sq        = 1'b0;
            n_comment   = 1'b0;
            n_esc       = 1'b0;
            n_word_open = 1'b0;
            n_rhw       = 1'b0;
            n_await     = 1'b1;
            n_nl        = '0;
            n_start     = '0;
        end else if (r_esc) begin
            n_esc = 1'b0;
            if (r_await) begin
                n_start = nl_inc;
                n_await = 1'b0;
            end
            if (c == qwt_pkg::CH_NL) begin
                n_nl = nl_inc;
            end
            n_word_open      = 1'b1;
            n_res.char_valid = 1'b1;
            n_res.char_out   = c;
        end else begin
            if (c == qwt_pkg::CH_NL) begin
                n_nl = nl_inc;
            end
            if (c == qwt_pkg::CH_NL && !quoted) begin
                n_comment       = 1'b0;
                n_res.word_done = r_word_open;
                n_word_open     = 1'b0;
                rhw_now         = r_rhw || r_word_open;
                if (rhw_now) begin
                    n_res.record_done = 1'b1;
                    n_res.record_line = qwt_pkg::to_rec_line(r_start);
                    n_await           = 1'b1;
                end
                n_rhw = 1'b0;
            end else begin
                comment_now = r_comment || (c == qwt_pkg::CH_HASH && !quoted);
                n_comment   = comment_now;
                priority if (comment_now) begin
                    n_comment = 1'b1;
                end else if (c == qwt_pkg::CH_BSL) begin
                    n_esc = 1'b1;
                end else if (c == qwt_pkg::CH_DQ && !r_sq) begin
                    n_dq = !r_dq;
                end else if (c == qwt_pkg::CH_SQ && !r_dq) begin
                    n_sq = !r_sq;
                end else if (!quoted && (c == qwt_pkg::CH_SPACE || c == qwt_pkg::CH_TAB)) begin
                    n_res.word_done = r_word_open;
                    n_word_open     = 1'b0;
                    if (r_word_open) begin
                        n_rhw = 1'b1;
                    end
                end else begin
                    if (r_await) begin
                        n_start = n_nl + qwt_pkg::t_line'(1);
                        n_await = 1'b0;
                    end
                    n_word_open      = 1'b1;
                    n_res.char_valid = 1'b1;
                    if (r_lower && c >= qwt_pkg::CH_UC_A && c <= qwt_pkg::CH_UC_Z) begin
                        n_res.char_out = c + qwt_pkg::CASE_OFS;
                    end else begin
                        n_res.char_out = c;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower     <= 1'b0;
            r_dq        <= 1'b0;
            r_sq        <= 1'b0;
            r_comment   <= 1'b0;
            r_esc       <= 1'b0;
            r_word_open <= 1'b0;
            r_rhw       <= 1'b0;
            r_await     <= 1'b1;
            r_nl        <= '0;
            r_start     <= '0;
            r_m_valid   <= 1'b0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == qwt_pkg::ADDR_LOWERCASE) begin
                r_lower <= pwdata[0];
            end
            if (accept) begin
                r_dq        <= n_dq;
                r_sq        <= n_sq;
                r_comment   <= n_comment;
                r_esc       <= n_esc;
                r_word_open <= n_word_open;
                r_rhw       <= n_rhw;
                r_await     <= n_await;
                r_nl        <= n_nl;
                r_start     <= n_start;
                r_m_valid   <= 1'b1;
            end else if (m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res  <= n_res;
            r_last <= n_last;
        end
    end

    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_tvalid)
        else $error("result register not empty after reset");

    a_qerr_eos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tlast |-> !m_tdata[35])
        else $error("quote error outside end of stream");

    a_word_no_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tlast && m_tdata[9] |-> !m_tdata[0])
        else $error("word closed on a byte that was appended");

    a_eos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && s_tuser == qwt_pkg::ACT_EOS
        |=> r_nl == '0 && !r_word_open && !r_esc && r_await)
        else $error("state not cleared after end of stream");

    a_no_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[8:1] == '0)
        else $error("char_out set without char_valid");

endmodule
